[design/usd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package usd_pkg;

  localparam int unsigned NormBits   = 16;
  localparam int unsigned WeightBits = 24;
  localparam int unsigned RecipShift = 35;

  localparam logic [2:0] SCH_CENTRAL2 = 3'd0;
  localparam logic [2:0] SCH_UPWIND1  = 3'd1;
  localparam logic [2:0] SCH_UPWIND2  = 3'd2;
  localparam logic [2:0] SCH_UPWIND3  = 3'd3;
  localparam logic [2:0] SCH_CENTRAL4 = 3'd4;
  localparam logic [2:0] SCH_WENO3    = 3'd5;
  localparam logic [2:0] SCH_RSVD6    = 3'd6;
  localparam logic [2:0] SCH_RSVD7    = 3'd7;

  localparam logic [7:0] CFG_SCHEME  = 8'd0;
  localparam logic [7:0] CFG_EPSILON = 8'd1;

  localparam logic [2:0]  SCHEME_RESET  = SCH_UPWIND1;
  localparam logic [31:0] EPSILON_RESET = 32'd1;

  localparam logic [31:0] LIMIT_POS   = 32'h7fff_ffff;
  localparam logic [31:0] LIMIT_NEG   = 32'h8000_0000;
  localparam logic [33:0] BOUND12_POS = 34'd6442450944;
  localparam logic [33:0] BOUND12_NEG = 34'd6442450947;
  localparam logic [33:0] RECIP_THREE = 34'd11453246123;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_DIV1,
    MODE_DIV2,
    MODE_DIV12,
    MODE_WENO
  } usd_mode_e;

  typedef struct packed {
    logic [31:0] sample_plus2;
    logic [31:0] sample_plus1;
    logic [31:0] sample_centre;
    logic [31:0] sample_minus1;
    logic [31:0] sample_minus2;
    logic [31:0] velocity;
  } usd_stencil_t;

  typedef struct packed {
    logic               vneg;
    logic [31:0]        vmag;
    logic signed [32:0] diff;
    logic signed [35:0] e;
    logic signed [36:0] s_lin;
    logic               den_zero;
    usd_mode_e          mode;
  } usd_carry_t;

endpackage

`default_nettype wire

[design/upwind_stencil_derivative_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: velocity, sample_minus2, sample_minus1, sample_centre,
//                       sample_plus1, sample_plus2 (32 bits each)
// m_axis    out  tdata: advection_term (32); tuser: saturated_flag
// cfg       in   index 0 scheme_select [2:0], index 1 weno_epsilon [31:0]
//
// One request per cycle while the pipeline is not held; 5 front stages, 25 divider
// steps for the WENO weight, 5 back stages and an output register.
// The whole pipeline advances together; it holds only when the output
// register is full and not taken and the last stage holds a result.
// Reset clears valid bits and sets scheme_select to 1 and weno_epsilon to 1.
module upwind_stencil_derivative_unit import usd_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [191:0] s_axis_tdata_i,  // velocity, minus2, minus1, centre, plus1, plus2
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o,  // advection_term
  output logic         m_axis_tuser_o,  // saturated_flag
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [2:0]  scheme_q;
  logic [31:0] epsilon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q  <= SCHEME_RESET;
      epsilon_q <= EPSILON_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SCHEME:  scheme_q  <= cfg_data_i[2:0];
        CFG_EPSILON: epsilon_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic                en;
  logic                out_load;
  logic                front_valid, div_valid, back_valid;
  usd_carry_t          front_carry, div_carry;
  logic [31:0]         numer;
  logic [33:0]         denom;
  logic [WeightBits:0] weight;
  logic [31:0]         term;
  logic                sat;

  assign out_load        = ~m_axis_tvalid_o | m_axis_tready_i;
  assign en              = out_load | ~back_valid;
  assign s_axis_tready_o = en;

  usd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid_i),
    .stencil_i (usd_stencil_t'(s_axis_tdata_i)),
    .scheme_i  (scheme_q),
    .epsilon_i (epsilon_q),
    .valid_o   (front_valid),
    .carry_o   (front_carry),
    .numer_o   (numer),
    .denom_o   (denom)
  );

  usd_divider u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (front_valid),
    .carry_i  (front_carry),
    .numer_i  (numer),
    .denom_i  (denom),
    .valid_o  (div_valid),
    .carry_o  (div_carry),
    .weight_o (weight)
  );

  usd_back #(
    .FractionBits (FRACTION_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (div_valid),
    .carry_i  (div_carry),
    .weight_i (weight),
    .valid_o  (back_valid),
    .term_o   (term),
    .sat_o    (sat)
  );

  logic        out_valid_q;
  logic [31:0] out_term_q;
  logic        out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= back_valid;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_term_q <= term;
      out_sat_q  <= sat;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_term_q;
  assign m_axis_tuser_o  = out_sat_q;

  a_unused_scheme_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (scheme_q == SCH_RSVD6 || scheme_q == SCH_RSVD7)
      |-> m_axis_tdata_o == '0 && !m_axis_tuser_o)
    else $error("unused scheme produced a nonzero result");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o
      |-> m_axis_tdata_o == LIMIT_POS || m_axis_tdata_o == LIMIT_NEG)
    else $error("saturated result not at a range limit");

endmodule

`default_nettype wire

[design/usd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module usd_front import usd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  usd_stencil_t stencil_i,
  input  logic [2:0]   scheme_i,
  input  logic [31:0]  epsilon_i,
  output logic         valid_o,
  output usd_carry_t   carry_o,
  output logic [31:0]  numer_o,
  output logic [33:0]  denom_o
);

  function automatic logic signed [37:0] sx38(logic [31:0] x);
    sx38 = {{6{x[31]}}, x};
  endfunction

  function automatic logic [5:0] norm_shift(logic [67:0] x);
    logic [6:0] len;
    len = '0;
    for (int i = 0; i < 68; i++) begin
      if (x[i]) len = 7'(i + 1);
    end
    norm_shift = (len > 7'(NormBits)) ? 6'(len - 7'(NormBits)) : 6'd0;
  endfunction

  logic signed [37:0] v_x, mm_x, m_x, c_x, p_x, pp_x;
  logic signed [37:0] a_up, a_dn, b_x, e_up, e_dn, lin_d;
  logic               v_pos, v_nneg;
  usd_mode_e          mode_d;
  usd_carry_t         carry_d;

  assign v_x  = sx38(stencil_i.velocity);
  assign mm_x = sx38(stencil_i.sample_minus2);
  assign m_x  = sx38(stencil_i.sample_minus1);
  assign c_x  = sx38(stencil_i.sample_centre);
  assign p_x  = sx38(stencil_i.sample_plus1);
  assign pp_x = sx38(stencil_i.sample_plus2);

  assign v_nneg = ~stencil_i.velocity[31];
  assign v_pos  = v_nneg & (|stencil_i.velocity);

  assign a_up = c_x - (m_x <<< 1) + mm_x;
  assign a_dn = pp_x - (p_x <<< 1) + c_x;
  assign b_x  = p_x - (c_x <<< 1) + m_x;
  assign e_up = p_x - mm_x + 38'sd3 * (m_x - c_x);
  assign e_dn = pp_x - m_x + 38'sd3 * (c_x - p_x);

  always_comb begin
    lin_d  = '0;
    mode_d = MODE_NONE;
    unique case (scheme_i)
      SCH_CENTRAL2: begin
        lin_d  = p_x - m_x;
        mode_d = MODE_DIV2;
      end
      SCH_UPWIND1: begin
        lin_d  = v_nneg ? (c_x - m_x) : (p_x - c_x);
        mode_d = MODE_DIV1;
      end
      SCH_UPWIND2: begin
        lin_d  = v_nneg ? (38'sd3 * c_x - 38'sd4 * m_x + mm_x)
                        : (38'sd4 * p_x - 38'sd3 * c_x - pp_x);
        mode_d = MODE_DIV2;
      end
      SCH_UPWIND3: begin
        lin_d  = v_nneg
          ? (38'sd4 * p_x - 38'sd12 * m_x + 38'sd2 * mm_x + 38'sd6 * c_x)
          : (38'sd12 * p_x - 38'sd4 * m_x - 38'sd2 * pp_x - 38'sd6 * c_x);
        mode_d = MODE_DIV12;
      end
      SCH_CENTRAL4: begin
        lin_d  = 38'sd8 * (p_x - m_x) + mm_x - pp_x;
        mode_d = MODE_DIV12;
      end
      SCH_WENO3: begin
        mode_d = MODE_WENO;
      end
      default: ;
    endcase
  end

  always_comb begin
    carry_d.vneg     = stencil_i.velocity[31];
    carry_d.vmag     = stencil_i.velocity[31] ? 32'(-v_x) : stencil_i.velocity;
    carry_d.diff     = 33'(p_x - m_x);
    carry_d.e        = 36'(v_pos ? e_up : e_dn);
    carry_d.s_lin    = 37'(lin_d);
    carry_d.den_zero = 1'b0;
    carry_d.mode     = mode_d;
  end

  // stage 1: differences
  logic               s1_valid_q;
  usd_carry_t         s1_carry_q;
  logic signed [34:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (en_i) s1_valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_carry_q <= carry_d;
      s1_a_q     <= 35'(v_pos ? a_up : a_dn);
      s1_b_q     <= 35'(b_x);
    end
  end

  // stage 2: squared curvatures
  logic [33:0] amag, bmag;
  logic [67:0] na_d, nb_d;
  logic        s2_valid_q;
  usd_carry_t  s2_carry_q;
  logic [67:0] s2_na_q, s2_nb_q;

  assign amag = s1_a_q[34] ? 34'(-s1_a_q) : 34'(s1_a_q);
  assign bmag = s1_b_q[34] ? 34'(-s1_b_q) : 34'(s1_b_q);
  assign na_d = ({34'd0, amag} * {34'd0, amag}) + {36'd0, epsilon_i};
  assign nb_d = ({34'd0, bmag} * {34'd0, bmag}) + {36'd0, epsilon_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (en_i) s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_carry_q <= s1_carry_q;
      s2_na_q    <= na_d;
      s2_nb_q    <= nb_d;
    end
  end

  // stage 3: common normalizing shift
  logic        s3_valid_q;
  usd_carry_t  s3_carry_q;
  logic [67:0] s3_na_q, s3_nb_q;
  logic [5:0]  s3_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_valid_q <= 1'b0;
    else if (en_i) s3_valid_q <= s2_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_carry_q <= s2_carry_q;
      s3_na_q    <= s2_na_q;
      s3_nb_q    <= s2_nb_q;
      s3_sh_q    <= norm_shift(s2_na_q | s2_nb_q);
    end
  end

  // stage 4: shifted norms
  logic        s4_valid_q;
  usd_carry_t  s4_carry_q;
  logic [15:0] s4_sa_q, s4_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_valid_q <= 1'b0;
    else if (en_i) s4_valid_q <= s3_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_carry_q <= s3_carry_q;
      s4_sa_q    <= 16'(s3_na_q >> s3_sh_q);
      s4_sb_q    <= 16'(s3_nb_q >> s3_sh_q);
    end
  end

  // stage 5: weight numerator and denominator
  logic [31:0] a2, b2;
  logic [33:0] den_d;
  usd_carry_t  s5_carry_d;
  logic        s5_valid_q;
  usd_carry_t  s5_carry_q;
  logic [31:0] s5_numer_q;
  logic [33:0] s5_denom_q;

  assign a2    = s4_sa_q * s4_sa_q;
  assign b2    = s4_sb_q * s4_sb_q;
  assign den_d = {2'b00, b2} + {1'b0, a2, 1'b0};

  always_comb begin
    s5_carry_d          = s4_carry_q;
    s5_carry_d.den_zero = (den_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_valid_q <= 1'b0;
    else if (en_i) s5_valid_q <= s4_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_carry_q <= s5_carry_d;
      s5_numer_q <= b2;
      s5_denom_q <= den_d;
    end
  end

  assign valid_o = s5_valid_q;
  assign carry_o = s5_carry_q;
  assign numer_o = s5_numer_q;
  assign denom_o = s5_denom_q;

endmodule

`default_nettype wire

[design/usd_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

module usd_divider import usd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  usd_carry_t          carry_i,
  input  logic [31:0]         numer_i,
  input  logic [33:0]         denom_i,
  output logic                valid_o,
  output usd_carry_t          carry_o,
  output logic [WeightBits:0] weight_o
);

  localparam int unsigned Steps = WeightBits + 1;

  logic                vld_q [Steps];
  usd_carry_t          cry_q [Steps];
  logic [33:0]         den_q [Steps];
  logic [34:0]         rem_q [Steps];
  logic [WeightBits:0] quo_q [Steps];

  logic                vin   [Steps];
  usd_carry_t          cin   [Steps];
  logic [33:0]         din   [Steps];
  logic [WeightBits:0] qin   [Steps];
  logic [34:0]         trial [Steps];
  logic                take  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    if (k == 0) begin : g_first
      assign vin[k]   = valid_i;
      assign cin[k]   = carry_i;
      assign din[k]   = denom_i;
      assign qin[k]   = '0;
      assign trial[k] = {3'b000, numer_i};
    end else begin : g_next
      assign vin[k]   = vld_q[k-1];
      assign cin[k]   = cry_q[k-1];
      assign din[k]   = den_q[k-1];
      assign qin[k]   = quo_q[k-1];
      assign trial[k] = {rem_q[k-1][33:0], 1'b0};
    end
    assign take[k] = (trial[k] >= {1'b0, din[k]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Steps; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < Steps; k++) vld_q[k] <= vin[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Steps; k++) begin
        cry_q[k] <= cin[k];
        den_q[k] <= din[k];
        rem_q[k] <= take[k] ? (trial[k] - {1'b0, din[k]}) : trial[k];
        quo_q[k] <= {qin[k][WeightBits-1:0], take[k]};
      end
    end
  end

  assign valid_o  = vld_q[Steps-1];
  assign carry_o  = cry_q[Steps-1];
  assign weight_o = quo_q[Steps-1];

endmodule

`default_nettype wire

[design/usd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module usd_back import usd_pkg::*; #(
  parameter int unsigned FractionBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  usd_carry_t          carry_i,
  input  logic [WeightBits:0] weight_i,
  output logic                valid_o,
  output logic [31:0]         term_o,
  output logic                sat_o
);

  localparam int unsigned ShOne   = FractionBits;
  localparam int unsigned ShTwo   = FractionBits + 1;
  localparam int unsigned ShTw    = FractionBits + 2;
  localparam int unsigned ShWeno  = FractionBits + WeightBits + 1;
  localparam logic [92:0] AddOne  = 93'(1) << (ShOne - 1);
  localparam logic [92:0] AddTwo  = 93'(1) << (ShTwo - 1);
  localparam logic [92:0] AddTw   = 93'(3) << (ShTw - 1);
  localparam logic [92:0] AddWeno = 93'(1) << (ShWeno - 1);

  // stage 1: weight times smoothness difference
  logic [WeightBits:0] w_eff;
  logic signed [60:0]  we_d;
  logic                b1_valid_q;
  usd_carry_t          b1_carry_q;
  logic signed [60:0]  b1_we_q;

  assign w_eff = carry_i.den_zero ? ((WeightBits + 1)'(1) << WeightBits) : weight_i;
  assign we_d  = 61'(signed'({1'b0, w_eff})) * 61'(carry_i.e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b1_valid_q <= 1'b0;
    else if (en_i) b1_valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_carry_q <= carry_i;
      b1_we_q    <= we_d;
    end
  end

  // stage 2: pick the difference, split sign and magnitude
  logic signed [60:0] t_d, sel_d;
  logic               b2_valid_q;
  logic               b2_neg_q;
  usd_mode_e          b2_mode_q;
  logic [31:0]        b2_vmag_q;
  logic [59:0]        b2_smag_q;

  assign t_d   = (61'(b1_carry_q.diff) <<< WeightBits) - b1_we_q;
  assign sel_d = (b1_carry_q.mode == MODE_WENO) ? t_d : 61'(b1_carry_q.s_lin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b2_valid_q <= 1'b0;
    else if (en_i) b2_valid_q <= b1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b2_neg_q  <= b1_carry_q.vneg ^ sel_d[60];
      b2_mode_q <= b1_carry_q.mode;
      b2_vmag_q <= b1_carry_q.vmag;
      b2_smag_q <= sel_d[60] ? 60'(-sel_d) : 60'(sel_d);
    end
  end

  // stage 3: partial products
  logic        b3_valid_q;
  logic        b3_neg_q;
  usd_mode_e   b3_mode_q;
  logic [63:0] b3_lo_q;
  logic [59:0] b3_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b3_valid_q <= 1'b0;
    else if (en_i) b3_valid_q <= b2_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b3_neg_q  <= b2_neg_q;
      b3_mode_q <= b2_mode_q;
      b3_lo_q   <= {32'd0, b2_vmag_q} * {32'd0, b2_smag_q[31:0]};
      b3_hi_q   <= {28'd0, b2_vmag_q} * {32'd0, b2_smag_q[59:32]};
    end
  end

  // stage 4: sum, round, scale
  logic [92:0] prod_d;
  logic [92:0] y_d;
  logic        b4_valid_q;
  logic        b4_neg_q;
  usd_mode_e   b4_mode_q;
  logic [92:0] b4_y_q;

  assign prod_d = {29'd0, b3_lo_q} + {1'b0, b3_hi_q, 32'd0};

  always_comb begin
    case (b3_mode_q)
      MODE_DIV2:  y_d = (prod_d + AddTwo) >> ShTwo;
      MODE_DIV12: y_d = (prod_d + AddTw) >> ShTw;
      MODE_WENO:  y_d = (prod_d + AddWeno) >> ShWeno;
      default:    y_d = (prod_d + AddOne) >> ShOne;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b4_valid_q <= 1'b0;
    else if (en_i) b4_valid_q <= b3_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b4_neg_q  <= b3_neg_q;
      b4_mode_q <= b3_mode_q;
      b4_y_q    <= y_d;
    end
  end

  // stage 5: range check, divide by three
  logic [31:0] limit;
  logic [33:0] bound12;
  logic        sat_d;
  logic        b5_valid_q;
  logic        b5_neg_q;
  logic        b5_sat_q;
  usd_mode_e   b5_mode_q;
  logic [31:0] b5_small_q;
  logic [67:0] b5_third_q;

  assign limit   = b4_neg_q ? LIMIT_NEG : LIMIT_POS;
  assign bound12 = b4_neg_q ? BOUND12_NEG : BOUND12_POS;
  assign sat_d   = (b4_mode_q == MODE_DIV12) ? (b4_y_q >= 93'(bound12))
                                             : (b4_y_q > 93'(limit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b5_valid_q <= 1'b0;
    else if (en_i) b5_valid_q <= b4_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b5_neg_q   <= b4_neg_q;
      b5_sat_q   <= sat_d;
      b5_mode_q  <= b4_mode_q;
      b5_small_q <= b4_y_q[31:0];
      b5_third_q <= {34'd0, b4_y_q[33:0]} * {34'd0, RECIP_THREE};
    end
  end

  logic [31:0] q;

  always_comb begin
    q = (b5_mode_q == MODE_DIV12) ? b5_third_q[RecipShift +: 32] : b5_small_q;
    if (b5_sat_q) q = b5_neg_q ? LIMIT_NEG : LIMIT_POS;
    if (b5_mode_q == MODE_NONE) begin
      term_o = '0;
      sat_o  = 1'b0;
    end else begin
      term_o = b5_neg_q ? (32'd0 - q) : q;
      sat_o  = b5_sat_q;
    end
  end

  assign valid_o = b5_valid_q;

endmodule

`default_nettype wire

[verif/upwind_stencil_derivative_unit_tb.sv]
`timescale 1ns / 1ps

module upwind_stencil_derivative_unit_tb;
  import usd_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DrainCycles = 80;

  typedef struct packed {
    logic [31:0] term;
    logic        sat;
  } adv_result_t;

  typedef struct {
    logic        is_cfg;
    logic [7:0]  index;
    logic [31:0] data;
    logic [191:0] stencil;
  } stim_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [191:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [31:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  upwind_stencil_derivative_unit #(.FRACTION_BITS(FracBits)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  stim_t       pending_q[$];
  adv_result_t expected_q[$];
  logic [2:0]  scheme_sel;
  logic [31:0] weno_eps;
  int          mismatches;
  int          stim_done;
  int          gap_left;
  int          burst_left;
  logic        hold_on;
  int          stall_phase;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic adv_result_t scale_and_clip(logic signed [63:0] v,
      logic signed [127:0] s, int unsigned extra, logic [63:0] div);
    adv_result_t r;
    logic [127:0] mv, ms, p, q, lim;
    logic neg;
    int unsigned sh;
    sh = FracBits + extra;
    neg = (v < 0) != (s < 0);
    mv = v < 0 ? 128'(-v) : 128'(v);
    ms = s < 0 ? 128'(-s) : 128'(s);
    p = mv * ms + (128'(div) << (sh - 1));
    p = p >> sh;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    r.sat = 1'b0;
    if (p[127:64] != 0) begin
      q = lim;
      r.sat = 1'b1;
    end else begin
      q = 128'(p[63:0] / div);
      if (q > lim) begin
        q = lim;
        r.sat = 1'b1;
      end
    end
    if (neg) q = -q;
    r.term = q[31:0];
    return r;
  endfunction

  function automatic int unsigned bit_length(logic [127:0] x);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 128; i++) if (x[i]) n = i + 1;
    return n;
  endfunction

  function automatic adv_result_t advection_of(logic [191:0] st);
    logic signed [63:0] v, mm, m, c, p, pp, a, e, b, s;
    logic [127:0] na, nb, sa, sb, a2, b2, den, w;
    logic signed [127:0] t;
    int unsigned len, sh;
    adv_result_t r;
    v  = 64'(signed'(st[31:0]));
    mm = 64'(signed'(st[63:32]));
    m  = 64'(signed'(st[95:64]));
    c  = 64'(signed'(st[127:96]));
    p  = 64'(signed'(st[159:128]));
    pp = 64'(signed'(st[191:160]));
    case (scheme_sel)
      SCH_CENTRAL2: r = scale_and_clip(v, 128'(p - m), 0, 2);
      SCH_UPWIND1: begin
        s = v >= 0 ? c - m : p - c;
        r = scale_and_clip(v, 128'(s), 0, 1);
      end
      SCH_UPWIND2: begin
        s = v >= 0 ? 3 * c - 4 * m + mm : -pp + 4 * p - 3 * c;
        r = scale_and_clip(v, 128'(s), 0, 2);
      end
      SCH_UPWIND3: begin
        s = v >= 0 ? 4 * p - 12 * m + 2 * mm + 6 * c : -4 * m + 12 * p - 2 * pp - 6 * c;
        r = scale_and_clip(v, 128'(s), 0, 12);
      end
      SCH_CENTRAL4: r = scale_and_clip(v, 128'(8 * p - 8 * m + mm - pp), 0, 12);
      SCH_WENO3: begin
        b = p - 2 * c + m;
        if (v > 0) begin
          a = c - 2 * m + mm;
          e = -mm + 3 * m - 3 * c + p;
        end else begin
          a = pp - 2 * p + c;
          e = -m + 3 * c - 3 * p + pp;
        end
        na = 128'(a < 0 ? -a : a);
        na = na * na + 128'(weno_eps);
        nb = 128'(b < 0 ? -b : b);
        nb = nb * nb + 128'(weno_eps);
        len = bit_length(na);
        if (bit_length(nb) > len) len = bit_length(nb);
        sh = len > NormBits ? len - NormBits : 0;
        sa = na >> sh;
        sb = nb >> sh;
        a2 = sa * sa;
        b2 = sb * sb;
        den = b2 + 2 * a2;
        w = den == 0 ? (128'd1 << WeightBits) : (b2 << WeightBits) / den;
        t = (128'(signed'(p - m)) <<< WeightBits) - signed'(w) * 128'(signed'(e));
        r = scale_and_clip(v, t, WeightBits, 2);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8191)) - 4096);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cfg(logic [7:0] idx, logic [31:0] val);
    stim_t s;
    s.is_cfg = 1'b1;
    s.index = idx;
    s.data = val;
    s.stencil = '0;
    pending_q.push_back(s);
  endtask

  task automatic push_stencil(logic [191:0] st);
    stim_t s;
    s.is_cfg = 1'b0;
    s.index = '0;
    s.data = '0;
    s.stencil = st;
    pending_q.push_back(s);
  endtask

  function automatic logic [191:0] random_stencil();
    logic [191:0] st;
    logic [31:0] base;
    int kind;
    kind = $urandom_range(0, 3);
    base = rand_sample();
    for (int k = 0; k < 6; k++) begin
      if (kind == 0) st[k*32 +: 32] = base + 32'($urandom_range(0, 255)) - 32'd128;
      else st[k*32 +: 32] = rand_sample();
    end
    st[31:0] = rand_sample();
    return st;
  endfunction

  // Driver: config writes wait for an idle pipeline, stencils go in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      cfg_valid_i     <= 1'b0;
      cfg_index_i     <= '0;
      cfg_data_i      <= '0;
      gap_left        <= 0;
      burst_left      <= 4;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_SCHEME) scheme_sel = cfg_data_i[2:0];
        else if (cfg_index_i == CFG_EPSILON) weno_eps = cfg_data_i;
      end else if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_q.push_back(advection_of(s_axis_tdata_i));
      end
      if ((cfg_valid_i && !cfg_ready_o) || (s_axis_tvalid_i && !s_axis_tready_o)) begin
      end else if (hold_on) begin
        s_axis_tvalid_i <= 1'b0;
        cfg_valid_i     <= 1'b0;
      end else if (gap_left > 0) begin
        s_axis_tvalid_i <= 1'b0;
        cfg_valid_i     <= 1'b0;
        gap_left        <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
        if (pending_q[0].is_cfg) begin
          s_axis_tvalid_i <= 1'b0;
          if (expected_q.size() == 0 && !m_axis_tvalid_o &&
              !(s_axis_tvalid_i && s_axis_tready_o)) begin
            cfg_index_i <= pending_q[0].index;
            cfg_data_i  <= pending_q[0].data;
            cfg_valid_i <= 1'b1;
            void'(pending_q.pop_front());
          end else begin
            cfg_valid_i <= 1'b0;
          end
        end else begin
          cfg_valid_i     <= 1'b0;
          s_axis_tdata_i  <= pending_q[0].stencil;
          s_axis_tvalid_i <= 1'b1;
          void'(pending_q.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
        cfg_valid_i     <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_phase     <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result term=%h sat=%b", m_axis_tdata_o, m_axis_tuser_o);
        end else if (expected_q[0].term !== m_axis_tdata_o ||
                     expected_q[0].sat !== m_axis_tuser_o) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch exp term=%h sat=%b got term=%h sat=%b",
                     expected_q[0].term, expected_q[0].sat,
                     m_axis_tdata_o, m_axis_tuser_o);
          void'(expected_q.pop_front());
        end else begin
          void'(expected_q.pop_front());
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 40) m_axis_tready_i <= 1'b1;
      else if (stall_phase < 70) m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      else m_axis_tready_i <= $urandom_range(0, 1);
    end
  end

  initial begin
    logic [2:0] schemes[8];
    logic [191:0] st;
    mismatches = 0;
    scheme_sel = SCHEME_RESET;
    weno_eps   = EPSILON_RESET;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    schemes = '{SCH_UPWIND1, SCH_CENTRAL2, SCH_UPWIND2, SCH_UPWIND3,
                SCH_CENTRAL4, SCH_WENO3, SCH_RSVD6, SCH_RSVD7};
    // Directed: extremes and special cases on the reset scheme, WENO and central2.
    push_stencil({6{32'h7fff_ffff}});
    push_stencil({6{32'h8000_0000}});
    push_stencil({32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000});
    push_stencil({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    push_stencil({32'h0005_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000});
    push_cfg(CFG_SCHEME, 32'(SCH_WENO3));
    push_cfg(CFG_EPSILON, 32'd0);
    push_stencil({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000});
    push_stencil({32'h0004_0000, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000});
    push_stencil({32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                  32'hffff_0000});
    push_cfg(CFG_EPSILON, 32'hffff_ffff);
    push_stencil({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff});
    push_stencil({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000});
    push_cfg(CFG_SCHEME, 32'hffff_fff8);
    push_cfg(8'd2, 32'h5);
    push_stencil({6{32'h1234_5678}});
    push_cfg(8'hff, 32'h3);
    for (int ph = 0; ph < 25; ph++) begin
      push_cfg(CFG_SCHEME, {29'($urandom), 3'b000} | 32'(schemes[ph % 8]));
      if (ph % 3 == 0) push_cfg(CFG_EPSILON, ph % 2 ? $urandom : 32'($urandom_range(0, 3)));
      for (int k = 0; k < 50; k++) begin
        st = random_stencil();
        if ($urandom_range(0, 9) == 0) st[31:0] = '0;
        push_stencil(st);
      end
    end
    wait (pending_q.size() == 0);
    stim_done = 1;
  end

  // Hold off once mid-run until the pipeline has fully drained.
  initial begin
    stim_done = 0;
    hold_on = 1'b0;
    wait (rst_ni && pending_q.size() > 0 && pending_q.size() < 600);
    @(posedge clk_i);
    hold_on = 1'b1;
    wait (expected_q.size() == 0);
    @(posedge clk_i);
    hold_on = 1'b0;
  end

  initial begin
    wait (stim_done == 1);
    wait (!s_axis_tvalid_i && !cfg_valid_i && expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("upwind_stencil_derivative_unit verification clean");
    end else begin
      $display("upwind_stencil_derivative_unit verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("upwind_stencil_derivative_unit verification failed");
    $finish;
  end

endmodule
